// File: design/odo_pkg.sv
package odo_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_V1,
    ST_MUL_V2,
    ST_DIV_V,
    ST_MUL_W1,
    ST_MUL_W2,
    ST_DIV_W,
    ST_MUL_D,
    ST_DIV_D,
    ST_CORDIC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_H1,
    ST_DIV_H,
    ST_MUL_H2,
    ST_DONE
  } state_e;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_TRACK  = 2'd1;
  localparam logic [1:0] CFG_TURN   = 2'd2;

  localparam logic [15:0] RADIUS_RST = 16'd10813;
  localparam logic [19:0] TRACK_RST  = 20'd40632;
  localparam logic [17:0] TURN_RST   = 18'd23452;

  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [47:0] TWO_PI_H    = 48'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [31:0]        PI_MUL      = 32'd843314857;

  localparam logic [36:0] DIV_SPEED = 37'd16106127360;
  localparam logic [36:0] DIV_USEC  = 37'd1000000;

  function automatic logic [27:0] atan_q28(input logic [4:0] idx);
    logic [27:0] r;
    case (idx)
      5'd0:  r = 28'd210828714;
      5'd1:  r = 28'd124459457;
      5'd2:  r = 28'd65760959;
      5'd3:  r = 28'd33381290;
      5'd4:  r = 28'd16755422;
      5'd5:  r = 28'd8385879;
      5'd6:  r = 28'd4193963;
      5'd7:  r = 28'd2097109;
      5'd8:  r = 28'd1048571;
      5'd9:  r = 28'd524287;
      5'd10: r = 28'd262144;
      5'd11: r = 28'd131072;
      5'd12: r = 28'd65536;
      5'd13: r = 28'd32768;
      5'd14: r = 28'd16384;
      5'd15: r = 28'd8192;
      5'd16: r = 28'd4096;
      5'd17: r = 28'd2048;
      5'd18: r = 28'd1024;
      5'd19: r = 28'd512;
      5'd20: r = 28'd256;
      5'd21: r = 28'd128;
      5'd22: r = 28'd64;
      5'd23: r = 28'd32;
      5'd24: r = 28'd16;
      5'd25: r = 28'd8;
      5'd26: r = 28'd4;
      5'd27: r = 28'd2;
      5'd28: r = 28'd1;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: design/diff_drive_odometry.sv
// Differential-drive odometry. Each request carries left and right wheel RPM and the
// elapsed time in microseconds; the block returns one result with the updated pose
// (x, y in Q15.16, heading in Q3.28), the linear speed, the yaw rate and a stationary
// flag. One item at a time is processed by a single bit-serial shift-add multiplier,
// a restoring divider and an iterative CORDIC unit that runs CORDIC_STEPS iterations.
// A multiply lasts longer the more significant bits its multiplier operand has, so the
// time from accepting a request to loading its result depends on operand values and on
// any wait for a stalled result. A new request is taken while the previous result still
// waits.
module diff_drive_odometry import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] rpm_left_i,
  input  logic signed [15:0] rpm_right_i,
  input  logic [19:0]        time_step_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] yaw_rate_o,
  output logic               stationary_o
);

  localparam int CiW = $clog2(CORDIC_STEPS);

  state_e state_q, state_d;
  logic run_q, run_d;
  logic out_valid_q, out_valid_d, load_out;

  logic [15:0] radius_q;
  logic [19:0] track_q;
  logic [17:0] turn_q;
  logic signed [31:0] x_q, y_q, hd_q;

  logic        sum_neg_q, diff_neg_q, stat_q;
  logic [16:0] absum_q, abdiff_q;
  logic [19:0] dt_q;
  logic [27:0] vmag_q;
  logic [31:0] wmag_q;
  logic [28:0] dist_q;
  logic [63:0] t_q;
  logic signed [33:0] cos_q, sin_q;

  logic [63:0] ma_q, macc_q;
  logic [31:0] mb_q;
  logic [63:0] dn_q;
  logic [36:0] dr_q, dd_q;
  logic [5:0]  dcnt_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [CiW-1:0] ci_q;
  logic flip_q;

  logic is_mul, is_div, is_cor, unit_done;
  logic [63:0] op_a, op_n;
  logic [31:0] op_b;
  logic [36:0] op_d;
  logic [24:0] trk30;

  logic signed [16:0] sum_in, diff_in;
  logic [37:0] rem_sh;
  logic        div_ge;
  logic [36:0] dr_n;
  logic [63:0] q_n;
  logic [31:0] wlim, wsat;

  logic signed [33:0] ang0, ang1, ang2, ang3;
  logic               flip_n;
  logic signed [33:0] xs, ys, cx_n, cy_n, cz_n, atan_s;
  logic [31:0] cmag, smag;

  logic [33:0] dmag;
  logic signed [47:0] d48, upd_base, upd_sum;
  logic        upd_neg;
  logic [45:0] stp;
  logic signed [47:0] st48, h0, h1, h2;
  logic signed [31:0] y_sel;

  assign sum_in  = 17'(rpm_left_i) + 17'(rpm_right_i);
  assign diff_in = 17'(rpm_right_i) - 17'(rpm_left_i);
  assign trk30   = 25'({track_q, 5'b0}) - 25'({track_q, 1'b0});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL_V1;
      ST_MUL_V1: if (unit_done) state_d = ST_MUL_V2;
      ST_MUL_V2: if (unit_done) state_d = ST_DIV_V;
      ST_DIV_V:  if (unit_done) state_d = ST_MUL_W1;
      ST_MUL_W1: if (unit_done) state_d = ST_MUL_W2;
      ST_MUL_W2: if (unit_done) state_d = ST_DIV_W;
      ST_DIV_W:  if (unit_done) state_d = ST_MUL_D;
      ST_MUL_D:  if (unit_done) state_d = ST_DIV_D;
      ST_DIV_D:  if (unit_done) state_d = ST_CORDIC;
      ST_CORDIC: if (unit_done) state_d = ST_MUL_X;
      ST_MUL_X:  if (unit_done) state_d = ST_MUL_Y;
      ST_MUL_Y:  if (unit_done) state_d = ST_MUL_H1;
      ST_MUL_H1: if (unit_done) state_d = ST_DIV_H;
      ST_DIV_H:  if (unit_done) state_d = ST_MUL_H2;
      ST_MUL_H2: if (unit_done) state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    is_cor = 1'b0;
    op_a   = '0;
    op_b   = '0;
    op_n   = '0;
    op_d   = '0;
    unique case (state_q)
      ST_MUL_V1: begin is_mul = 1'b1; op_a = 64'(absum_q);  op_b = 32'(radius_q); end
      ST_MUL_V2: begin is_mul = 1'b1; op_a = t_q;           op_b = PI_MUL; end
      ST_DIV_V:  begin is_div = 1'b1; op_n = t_q;           op_d = DIV_SPEED; end
      ST_MUL_W1: begin is_mul = 1'b1; op_a = 64'(abdiff_q); op_b = 32'(radius_q); end
      ST_MUL_W2: begin is_mul = 1'b1; op_a = t_q;           op_b = PI_MUL; end
      ST_DIV_W:  begin is_div = 1'b1; op_n = t_q;           op_d = {trk30, 12'b0}; end
      ST_MUL_D:  begin is_mul = 1'b1; op_a = 64'(vmag_q);   op_b = 32'(dt_q); end
      ST_DIV_D:  begin is_div = 1'b1; op_n = t_q;           op_d = DIV_USEC; end
      ST_CORDIC: is_cor = 1'b1;
      ST_MUL_X:  begin is_mul = 1'b1; op_a = 64'(dist_q);   op_b = cmag; end
      ST_MUL_Y:  begin is_mul = 1'b1; op_a = 64'(dist_q);   op_b = smag; end
      ST_MUL_H1: begin is_mul = 1'b1; op_a = 64'(wmag_q);   op_b = 32'(dt_q); end
      ST_DIV_H:  begin is_div = 1'b1; op_n = {t_q[51:0], 12'b0}; op_d = DIV_USEC; end
      ST_MUL_H2: begin is_mul = 1'b1; op_a = t_q;           op_b = 32'(turn_q); end
      default: ;
    endcase
    unit_done = run_q && ((is_mul && (mb_q == '0)) ||
                          (is_div && (dcnt_q == 6'd63)) ||
                          (is_cor && (ci_q == CiW'(CORDIC_STEPS - 1))));
    if (is_mul || is_div || is_cor) run_d = !run_q || !unit_done;
    else run_d = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);
    load_out    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_comb begin
    rem_sh = {dr_q, dn_q[63]};
    div_ge = rem_sh >= {1'b0, dd_q};
    dr_n   = div_ge ? 37'(rem_sh - {1'b0, dd_q}) : rem_sh[36:0];
    q_n    = {dn_q[62:0], div_ge};
    wlim   = diff_neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
    if (track_q == '0) wsat = '0;
    else if (q_n > 64'(wlim)) wsat = wlim;
    else wsat = q_n[31:0];

    ang0 = 34'(hd_q);
    ang1 = (ang0 > PI_Q28) ? ang0 - TWO_PI_Q28 : ang0;
    ang2 = (ang1 < -PI_Q28) ? ang1 + TWO_PI_Q28 : ang1;
    flip_n = 1'b1;
    if (ang2 > HALF_PI_Q28) ang3 = ang2 - PI_Q28;
    else if (ang2 < -HALF_PI_Q28) ang3 = ang2 + PI_Q28;
    else begin
      ang3   = ang2;
      flip_n = 1'b0;
    end

    xs     = cx_q >>> ci_q;
    ys     = cy_q >>> ci_q;
    atan_s = $signed({6'b0, atan_q28(5'(ci_q))});
    if (!cz_q[33]) begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      cz_n = cz_q - atan_s;
    end else begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      cz_n = cz_q + atan_s;
    end
    cmag = 32'(cos_q[33] ? -cos_q : cos_q);
    smag = 32'(sin_q[33] ? -sin_q : sin_q);

    dmag     = 34'((macc_q + 64'h2000_0000) >> 30);
    d48      = $signed({14'b0, dmag});
    upd_neg  = sum_neg_q ^ ((state_q == ST_MUL_X) ? cos_q[33] : sin_q[33]);
    y_sel    = (state_q == ST_MUL_X) ? x_q : y_q;
    upd_base = 48'(y_sel);
    upd_sum  = upd_base + (upd_neg ? -d48 : d48);

    stp  = 46'((macc_q + 64'h8000) >> 16);
    st48 = $signed({2'b0, stp});
    h0   = 48'(hd_q) + (diff_neg_q ? -st48 : st48);
    h1   = (h0 >= TWO_PI_H) ? h0 - TWO_PI_H : h0;
    h2   = (h1 <= -TWO_PI_H) ? h1 + TWO_PI_H : h1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      radius_q    <= RADIUS_RST;
      track_q     <= TRACK_RST;
      turn_q      <= TURN_RST;
      x_q         <= '0;
      y_q         <= '0;
      hd_q        <= '0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS: radius_q <= cfg_data_i[15:0];
          CFG_TRACK:  track_q  <= cfg_data_i;
          CFG_TURN:   turn_q   <= cfg_data_i[17:0];
          default: ;
        endcase
      end
      if (unit_done) begin
        case (state_q)
          ST_MUL_X:  x_q  <= sat32(upd_sum);
          ST_MUL_Y:  y_q  <= sat32(upd_sum);
          ST_MUL_H2: hd_q <= sat32(h2);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      sum_neg_q  <= sum_in[16];
      diff_neg_q <= diff_in[16];
      absum_q    <= 17'(sum_in[16] ? -sum_in : sum_in);
      abdiff_q   <= 17'(diff_in[16] ? -diff_in : diff_in);
      dt_q       <= time_step_us_i;
      stat_q     <= (rpm_left_i == '0) && (rpm_right_i == '0);
    end
    if (is_mul) begin
      if (!run_q) begin
        ma_q   <= op_a;
        mb_q   <= op_b;
        macc_q <= '0;
      end else if (mb_q == '0) begin
        t_q <= macc_q;
      end else begin
        if (mb_q[0]) macc_q <= macc_q + ma_q;
        ma_q <= {ma_q[62:0], 1'b0};
        mb_q <= {1'b0, mb_q[31:1]};
      end
    end
    if (is_div) begin
      if (!run_q) begin
        dn_q   <= op_n + 64'(op_d >> 1);
        dr_q   <= '0;
        dd_q   <= op_d;
        dcnt_q <= '0;
      end else begin
        dn_q   <= q_n;
        dr_q   <= dr_n;
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          t_q <= q_n;
          case (state_q)
            ST_DIV_V: vmag_q <= q_n[27:0];
            ST_DIV_W: wmag_q <= wsat;
            ST_DIV_D: dist_q <= q_n[28:0];
            default: ;
          endcase
        end
      end
    end
    if (is_cor) begin
      if (!run_q) begin
        cx_q   <= GAIN_Q30;
        cy_q   <= '0;
        cz_q   <= ang3;
        flip_q <= flip_n;
        ci_q   <= '0;
      end else begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        ci_q <= ci_q + CiW'(1);
        if (ci_q == CiW'(CORDIC_STEPS - 1)) begin
          cos_q <= flip_q ? -cx_n : cx_n;
          sin_q <= flip_q ? -cy_n : cy_n;
        end
      end
    end
    if (load_out) begin
      pos_x_o        <= x_q;
      pos_y_o        <= y_q;
      heading_o      <= hd_q;
      linear_speed_o <= sum_neg_q ? -$signed({4'b0, vmag_q}) : $signed({4'b0, vmag_q});
      yaw_rate_o     <= diff_neg_q ? 32'(32'd0 - wmag_q) : $signed(wmag_q);
      stationary_o   <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !run_q)
    else $error("arithmetic unit running while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL_V1))
    else $error("accepted request did not start processing");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result presented without finishing an item");

endmodule
